/* hdl/ship_rrip_replacement_assert.svh */
// assertion macros shared by the replacement policy rtl
// depends on a signal named clock and a signal named reset at the point of use
`ifndef SHIP_RRIP_REPLACEMENT_ASSERT_SVH
`define SHIP_RRIP_REPLACEMENT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHIP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SHIP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ship_pkg.sv */
// shared types and constants for the replacement policy block
// no dependencies
package ship_pkg;

   // fixed field widths of the request and result transfers
   localparam int SET_IDX_W  = 11;
   localparam int WAY_IDX_W  = 4;
   localparam int PC_W       = 22;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int THR_W      = 3;
   localparam logic [THR_W-1:0] THR_RESET = 3'd3;
   localparam logic CSR_THRESHOLD = 1'b0;

   // request opcodes
   localparam logic ACT_VICTIM = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_UPD_ROW,
      ST_UPD_CNT,
      ST_VICT
   } state_type;

   typedef struct packed {
      logic rd;
      logic clear;
      logic victim_wr;
      logic update_wr;
      logic hit;
   } line_ctl_type;

   typedef struct packed {
      logic rd;
      logic clear;
      logic wr;
      logic hit;
      logic was_hot;
   } sig_ctl_type;

endpackage

/* hdl/ship_set_map.sv */
// reduces the request set index modulo the number of sets
// depends on ship_pkg
module ship_set_map #(
   parameter int NUM_SETS = 2048,
   parameter int SET_AW   = 11
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ship_pkg::SET_IDX_W-1:0] set_in,
   output logic                           done,
   output logic [SET_AW-1:0]              set_out
);
   import ship_pkg::*;

   localparam int  EXT_W   = 17;
   localparam bit  IS_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         logic [EXT_W-1:0] ext;
         assign ext     = EXT_W'(set_in) & EXT_W'(NUM_SETS - 1);
         assign set_out = ext[SET_AW-1:0];
         assign done    = start;
      end else begin : g_recip
         // floor reciprocal: quotient is exact or one low, fixed by one subtract
         localparam int RECIP_SHIFT = 22;
         localparam int RECIP_W     = 23;
         localparam int PROD_W      = SET_IDX_W + RECIP_W;
         localparam int BACK_W      = SET_IDX_W + EXT_W;
         localparam logic [RECIP_W-1:0] RECIP =
            RECIP_W'((64'd1 << RECIP_SHIFT) / NUM_SETS);

         logic [SET_IDX_W-1:0] s_ff, q_ff, p_ff, rem;
         logic [PROD_W-1:0]    prod;
         logic [BACK_W-1:0]    back;
         logic [EXT_W-1:0]     rem_ext, red;
         logic                 v1_ff, v2_ff;

         assign prod    = PROD_W'(set_in) * PROD_W'(RECIP);
         assign back    = BACK_W'(q_ff) * BACK_W'(NUM_SETS);
         assign rem     = s_ff - p_ff;
         assign rem_ext = EXT_W'(rem);
         assign red     = (rem_ext >= EXT_W'(NUM_SETS)) ? rem_ext - EXT_W'(NUM_SETS)
                                                        : rem_ext;
         assign set_out = red[SET_AW-1:0];
         assign done    = v2_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               v1_ff <= 1'b0;
               v2_ff <= 1'b0;
            end else begin
               v1_ff <= start;
               v2_ff <= v1_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               s_ff <= set_in;
               q_ff <= prod[RECIP_SHIFT +: SET_IDX_W];
            end
            if (v1_ff) begin
               p_ff <= back[SET_IDX_W-1:0];
            end
         end
      end
   endgenerate

endmodule

/* hdl/ship_line_store.sv */
// per-set line metadata memory with aging, victim choice and update merge
// depends on ship_pkg
module ship_line_store #(
   parameter int NUM_SETS   = 2048,
   parameter int NUM_WAYS   = 16,
   parameter int RRPV_WIDTH = 2,
   parameter int SIG_WIDTH  = 10,
   parameter int SET_AW     = 11,
   parameter int WAY_AW     = 4
) (
   input  logic                   clock,
   input  ship_pkg::line_ctl_type ctl,
   input  logic [SET_AW-1:0]      addr,
   input  logic [WAY_AW-1:0]      way_sel,
   input  logic [SIG_WIDTH-1:0]   new_sig,
   input  logic                   insert_hot,
   output logic [SIG_WIDTH-1:0]   old_sig,
   output logic                   old_hot,
   output logic [WAY_AW-1:0]      victim_way
);
   import ship_pkg::*;

   localparam int NUM_LEVELS = 1 << RRPV_WIDTH;
   localparam logic [RRPV_WIDTH-1:0] RRPV_TOP = '1;

   typedef struct packed {
      logic [NUM_WAYS-1:0][SIG_WIDTH-1:0]  sig;
      logic [NUM_WAYS-1:0][RRPV_WIDTH-1:0] rrpv;
   } row_type;

   row_type mem [NUM_SETS];
   row_type rd_row_ff;
   row_type aged_row, upd_row, clr_row, wr_row;

   logic [NUM_LEVELS-1:0] present;
   logic [RRPV_WIDTH-1:0] top_val, lift;
   logic                  found;

   // which re-reference levels occur in the set
   always_comb begin
      present = '0;
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (rd_row_ff.rrpv[w] == RRPV_WIDTH'(lv)) begin
               present[lv] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      top_val = '0;
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
         if (present[lv]) begin
            top_val = RRPV_WIDTH'(lv);
         end
      end
      lift = RRPV_TOP - top_val;
   end

   // aging lifts the largest value to the top, so the victim is the first max way
   always_comb begin
      aged_row   = rd_row_ff;
      victim_way = '0;
      found      = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged_row.rrpv[w] = rd_row_ff.rrpv[w] + lift;
         if (!found && rd_row_ff.rrpv[w] == top_val) begin
            victim_way = WAY_AW'(w);
            found      = 1'b1;
         end
      end
   end

   always_comb begin
      upd_row = rd_row_ff;
      upd_row.rrpv[way_sel] = (ctl.hit || insert_hot) ? '0 : RRPV_TOP;
      if (!ctl.hit) begin
         upd_row.sig[way_sel] = new_sig;
      end
   end

   always_comb begin
      clr_row.rrpv = '1;
      clr_row.sig  = '0;
   end

   always_comb begin
      priority if (ctl.clear) begin
         wr_row = clr_row;
      end else if (ctl.victim_wr) begin
         wr_row = aged_row;
      end else begin
         wr_row = upd_row;
      end
   end

   assign old_sig = rd_row_ff.sig[way_sel];
   assign old_hot = rd_row_ff.rrpv[way_sel] == '0;

   always_ff @(posedge clock) begin
      if (ctl.clear || ctl.victim_wr || ctl.update_wr) begin
         mem[addr] <= wr_row;
      end
      if (ctl.rd) begin
         rd_row_ff <= mem[addr];
      end
   end

endmodule

/* hdl/ship_sig_table.sv */
// signature counter memory with saturating update and insertion decision
// depends on ship_pkg
module ship_sig_table #(
   parameter int SIG_WIDTH   = 10,
   parameter int COUNTER_MAX = 7,
   parameter int CNT_W       = 3
) (
   input  logic                       clock,
   input  ship_pkg::sig_ctl_type      ctl,
   input  logic [SIG_WIDTH-1:0]       new_sig,
   input  logic [SIG_WIDTH-1:0]       old_addr,
   input  logic [ship_pkg::THR_W-1:0] threshold,
   output logic                       insert_hot
);
   import ship_pkg::*;

   localparam int SIG_COUNT = 1 << SIG_WIDTH;
   localparam int CMP_W     = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(COUNTER_MAX);
   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(COUNTER_MAX / 2);

   logic [CNT_W-1:0] mem [SIG_COUNT];
   logic [CNT_W-1:0] new_cnt_ff, old_cnt_ff;
   logic [CNT_W-1:0] old_next, eff_cnt, wr_cnt;

   always_comb begin
      old_next = old_cnt_ff;
      if (ctl.hit) begin
         if (old_cnt_ff != CNT_MAX) begin
            old_next = old_cnt_ff + 1'b1;
         end
      end else if (ctl.was_hot && old_cnt_ff != '0) begin
         old_next = old_cnt_ff - 1'b1;
      end
   end

   // new signature equal to the evicted one sees the updated count
   assign eff_cnt    = (new_sig == old_addr) ? old_next : new_cnt_ff;
   assign insert_hot = CMP_W'(eff_cnt) > CMP_W'(threshold);
   assign wr_cnt     = ctl.clear ? CNT_RESET : old_next;

   always_ff @(posedge clock) begin
      if (ctl.clear || ctl.wr) begin
         mem[old_addr] <= wr_cnt;
      end
      if (ctl.rd) begin
         new_cnt_ff <= mem[new_sig];
         old_cnt_ff <= mem[old_addr];
      end
   end

endmodule

/* hdl/ship_rrip_replacement.sv */
// top level of the signature-guided rrip replacement policy
// depends on ship_pkg, ship_set_map, ship_line_store, ship_sig_table
//
// usage: a victim request (action 0) returns one transfer on rsp_ naming the
// first way at the top re-reference value after the set has been aged; an
// update (action 1) promotes a hit way or inserts a filled way and returns
// nothing. one request is in flight at a time. after acceptance, the next
// request is taken once the registered read of the set row is done and, for
// updates, also the counter read addressed by the stored signature of the
// line. when NUM_SETS is not a power of two, the registered set reduction
// comes first in each request. a finished victim waits in the output
// register while the next request is accepted; a second victim stalls only
// at its last step. after reset the block runs a clearing pass over every
// row and every counter with req_ready low; configuration writes are taken
// during the pass. the insertion threshold register sits at byte address 0
// of the apb-style port, pready is tied high.
`include "ship_rrip_replacement_assert.svh"

module ship_rrip_replacement #(
   parameter int NUM_SETS    = 2048,
   parameter int NUM_WAYS    = 16,
   parameter int RRPV_WIDTH  = 2,
   parameter int SIG_WIDTH   = 10,
   parameter int COUNTER_MAX = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [ship_pkg::SET_IDX_W-1:0]  req_set_index,
   input  logic [ship_pkg::WAY_IDX_W-1:0]  req_way_index,
   input  logic                            req_was_hit,
   input  logic [ship_pkg::PC_W-1:0]       req_pc_bits,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ship_pkg::WAY_IDX_W-1:0]  rsp_victim_way,
   // configuration port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ship_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ship_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ship_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import ship_pkg::*;

   localparam int SET_AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_AW    = $clog2(NUM_WAYS);
   localparam int CNT_W     = $clog2(COUNTER_MAX + 1);
   localparam int SIG_COUNT = 1 << SIG_WIDTH;
   localparam int CLR_CNT   = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
   localparam int CLR_W     = $clog2(CLR_CNT);
   localparam int CLR_CMP_W = CLR_W + 1;
   localparam int WAY_CMP_W = 6;

   // control state
   state_type            state_ff, state_in;
   logic [CLR_W-1:0]     clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [THR_W-1:0]     thr_ff, thr_in;

   // request held for the duration of its work
   logic                 action_ff;
   logic [WAY_IDX_W-1:0] way_ff;
   logic                 hit_ff;
   logic [SIG_WIDTH-1:0] sig_ff;
   logic [SET_AW-1:0]    set_ff;
   logic [WAY_IDX_W-1:0] rsp_way_ff, rsp_way_in;

   logic                 accept, issue, out_free, load_rsp;
   logic                 map_done, way_ok, clr_row_en, clr_sig_en;
   logic [SET_AW-1:0]    map_set, line_addr;
   logic [WAY_AW-1:0]    way_sel, victim_way;
   logic [4:0]           way_ext, victim_ext;
   logic [31:0]          pc_ext;
   logic [SIG_WIDTH-1:0] req_sig, old_sig, sig_old_addr;
   logic                 old_hot, insert_hot;
   logic                 csr_wr, csr_idx;

   line_ctl_type         line_ctl;
   sig_ctl_type          sig_ctl;

   // signature hash of the access pc
   assign pc_ext  = 32'(req_pc_bits);
   assign req_sig = SIG_WIDTH'((pc_ext >> 2) ^ (pc_ext >> (2 + SIG_WIDTH)));

   // requests are taken only while idle
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ways beyond the configured count leave everything untouched
   assign way_ext = 5'(way_ff);
   assign way_sel = way_ext[WAY_AW-1:0];
   assign way_ok  = WAY_CMP_W'(way_ff) < WAY_CMP_W'(NUM_WAYS);

   // clearing pass covers rows and counters in the same sweep
   assign clr_row_en = (state_ff == ST_CLEAR) && (CLR_CMP_W'(clr_ff) < CLR_CMP_W'(NUM_SETS));
   assign clr_sig_en = (state_ff == ST_CLEAR) && (CLR_CMP_W'(clr_ff) < CLR_CMP_W'(SIG_COUNT));

   ship_set_map #(
      .NUM_SETS (NUM_SETS),
      .SET_AW   (SET_AW)
   ) u_set_map (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .set_in   (req_set_index),
      .done     (map_done),
      .set_out  (map_set)
   );

   // next state and per-cycle strobes
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      issue    = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_CNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (map_done) begin
                  issue    = 1'b1;
                  state_in = (req_action == ACT_VICTIM) ? ST_VICT : ST_UPD_ROW;
               end else begin
                  state_in = ST_MAP;
               end
            end
         end
         ST_MAP: begin
            if (map_done) begin
               issue    = 1'b1;
               state_in = (action_ff == ACT_VICTIM) ? ST_VICT : ST_UPD_ROW;
            end
         end
         ST_UPD_ROW: begin
            state_in = ST_UPD_CNT;
         end
         ST_UPD_CNT: begin
            state_in = ST_IDLE;
         end
         ST_VICT: begin
            // hold the row until the output register can take the victim
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // row address: sweep, freshly reduced set at issue, then the held set
   always_comb begin
      priority if (state_ff == ST_CLEAR) begin
         line_addr = clr_ff[SET_AW-1:0];
      end else if (issue) begin
         line_addr = map_set;
      end else begin
         line_addr = set_ff;
      end
   end

   assign sig_old_addr = (state_ff == ST_CLEAR) ? clr_ff[SIG_WIDTH-1:0] : old_sig;

   always_comb begin
      line_ctl.rd        = issue;
      line_ctl.clear     = clr_row_en;
      line_ctl.victim_wr = load_rsp;
      line_ctl.update_wr = (state_ff == ST_UPD_CNT) && way_ok;
      line_ctl.hit       = hit_ff;
   end

   always_comb begin
      sig_ctl.rd      = (state_ff == ST_UPD_ROW) && way_ok;
      sig_ctl.clear   = clr_sig_en;
      sig_ctl.wr      = (state_ff == ST_UPD_CNT) && way_ok;
      sig_ctl.hit     = hit_ff;
      sig_ctl.was_hot = old_hot;
   end

   ship_line_store #(
      .NUM_SETS   (NUM_SETS),
      .NUM_WAYS   (NUM_WAYS),
      .RRPV_WIDTH (RRPV_WIDTH),
      .SIG_WIDTH  (SIG_WIDTH),
      .SET_AW     (SET_AW),
      .WAY_AW     (WAY_AW)
   ) u_line_store (
      .clock      (clock),
      .ctl        (line_ctl),
      .addr       (line_addr),
      .way_sel    (way_sel),
      .new_sig    (sig_ff),
      .insert_hot (insert_hot),
      .old_sig    (old_sig),
      .old_hot    (old_hot),
      .victim_way (victim_way)
   );

   ship_sig_table #(
      .SIG_WIDTH   (SIG_WIDTH),
      .COUNTER_MAX (COUNTER_MAX),
      .CNT_W       (CNT_W)
   ) u_sig_table (
      .clock       (clock),
      .ctl         (sig_ctl),
      .new_sig     (sig_ff),
      .old_addr    (sig_old_addr),
      .threshold   (thr_ff),
      .insert_hot  (insert_hot)
   );

   // result register, victim way masked to the port width
   assign victim_ext   = 5'(victim_way);
   assign rsp_way_in   = load_rsp ? victim_ext[WAY_IDX_W-1:0] : rsp_way_ff;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;

   // configuration register, decoded by word
   assign csr_idx = paddr[2];
   assign csr_wr  = psel && penable && pwrite && pready;
   assign thr_in  = (csr_wr && csr_idx == CSR_THRESHOLD) ? pwdata[THR_W-1:0] : thr_ff;
   assign prdata  = (csr_idx == CSR_THRESHOLD) ? CSR_DATA_W'(thr_ff) : '0;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         way_ff    <= req_way_index;
         hit_ff    <= req_was_hit;
         sig_ff    <= req_sig;
      end
      if (issue) begin
         set_ff <= map_set;
      end
      rsp_way_ff <= rsp_way_in;
   end

   // a new result only comes out of the victim step
   `SHIP_ASSERT_IMP(a_rsp_from_victim, $rose(rsp_valid_ff), $past(state_ff) == ST_VICT, "result loaded outside victim step")
   // a blocked victim keeps its row and waits
   `SHIP_ASSERT_NXT(a_victim_waits, state_ff == ST_VICT && rsp_valid_ff && !rsp_ready, state_ff == ST_VICT, "victim left while output full")
   // row read and row write never share a cycle
   `SHIP_ASSERT_IMP(a_row_rw_apart, line_ctl.rd, !(line_ctl.victim_wr || line_ctl.update_wr || line_ctl.clear), "row read collides with row write")

endmodule

/* tb/tb_top.sv */
// self-checking bench for ship_rrip_replacement: directed rows, then three random phases
// depends on ship_pkg and the ship_rrip_replacement rtl
// keeps its own copy of the rrip, signature and counter state to predict each victim way
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ship_pkg::*;

   // block geometry, matching the defaults of the dut
   localparam int NUM_WAYS   = 16;
   localparam int NUM_SETS   = 2048;
   localparam int SIG_W      = 10;
   localparam int LINE_COUNT = NUM_SETS * NUM_WAYS;
   localparam logic [1:0] RRPV_TOP = 2'd3;
   localparam logic [2:0] CTR_MAX  = 3'd7;
   localparam logic [2:0] CTR_MID  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] THR_ADDR = CSR_ADDR_W'(4 * CSR_THRESHOLD);
   // an update returns nothing, so after the last victim the block may still be busy
   localparam int SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_action    = ACT_VICTIM;
   logic [SET_IDX_W-1:0]  req_set_index = '0;
   logic [WAY_IDX_W-1:0]  req_way_index = '0;
   logic                  req_was_hit   = 1'b0;
   logic [PC_W-1:0]       req_pc_bits   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [WAY_IDX_W-1:0]  rsp_victim_way;
   logic                  psel          = 1'b0;
   logic                  penable       = 1'b0;
   logic                  pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr         = '0;
   logic [CSR_DATA_W-1:0] pwdata        = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ship_rrip_replacement dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_set_index  (req_set_index),
      .req_way_index  (req_way_index),
      .req_was_hit    (req_was_hit),
      .req_pc_bits    (req_pc_bits),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_victim_way (rsp_victim_way),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #1 clock = ~clock;

   // predicted replacement state
   logic [1:0]       line_rrpv [LINE_COUNT];
   logic [SIG_W-1:0] line_sig  [LINE_COUNT];
   logic [2:0]       sig_ctr   [1 << SIG_W];
   logic [THR_W-1:0] insert_thr;

   // victim ways still owed by the dut, oldest first
   logic [WAY_IDX_W-1:0] victim_ways_due [$];
   logic [WAY_IDX_W-1:0] last_victim;
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // one row of the directed table; typed rows carry their own expected way
   typedef struct packed {
      logic                 action;
      logic [SET_IDX_W-1:0] set_idx;
      logic [WAY_IDX_W-1:0] way;
      logic                 hit;
      logic [PC_W-1:0]      pc;
      logic                 typed;
      logic [WAY_IDX_W-1:0] typed_way;
   } dir_row_type;

   localparam int DIR_ROWS = 18;
   dir_row_type dir_table [DIR_ROWS] = '{
      // every line starts at the top value, so the first way is the victim
      '{ACT_VICTIM, 11'd0,    4'd0,  1'b0, 22'h000000, 1'b1, 4'd0},
      '{ACT_VICTIM, 11'd2047, 4'd0,  1'b0, 22'h000000, 1'b1, 4'd0},
      // hit on a fresh line promotes it and rewards signature 0
      '{ACT_UPDATE, 11'd0,    4'd0,  1'b1, 22'h000000, 1'b0, 4'd0},
      // way 0 is now hot, way 1 is the first line still at the top
      '{ACT_VICTIM, 11'd0,    4'd1,  1'b0, 22'h000000, 1'b1, 4'd1},
      // all-ones pc hashes to signature 0, whose counter is now above the threshold
      '{ACT_UPDATE, 11'd0,    4'd15, 1'b0, 22'h3FFFFF, 1'b0, 4'd0},
      // signature 0x3ff sits at the midpoint, equal to the threshold: cold insert
      '{ACT_UPDATE, 11'd0,    4'd1,  1'b0, 22'h000FFC, 1'b0, 4'd0},
      // repeated hits drive the counter into saturation at the top
      '{ACT_UPDATE, 11'd0,    4'd0,  1'b1, 22'h155555, 1'b0, 4'd0},
      '{ACT_UPDATE, 11'd0,    4'd0,  1'b1, 22'h2AAAAA, 1'b0, 4'd0},
      '{ACT_UPDATE, 11'd0,    4'd0,  1'b1, 22'h000000, 1'b0, 4'd0},
      '{ACT_UPDATE, 11'd0,    4'd0,  1'b1, 22'h3FFFFF, 1'b0, 4'd0},
      // fills over hot lines punish the evicted signature
      '{ACT_UPDATE, 11'd0,    4'd0,  1'b0, 22'h001234, 1'b0, 4'd0},
      '{ACT_UPDATE, 11'd0,    4'd15, 1'b0, 22'h2AAAAA, 1'b0, 4'd0},
      '{ACT_VICTIM, 11'd0,    4'd0,  1'b0, 22'h000000, 1'b0, 4'd0},
      '{ACT_UPDATE, 11'd2047, 4'd15, 1'b1, 22'h3FFFFF, 1'b0, 4'd0},
      '{ACT_UPDATE, 11'd2047, 4'd15, 1'b0, 22'h155555, 1'b0, 4'd0},
      '{ACT_VICTIM, 11'd2047, 4'd0,  1'b0, 22'h000000, 1'b0, 4'd0},
      '{ACT_UPDATE, 11'd1,    4'd7,  1'b0, 22'h3FF000, 1'b0, 4'd0},
      '{ACT_VICTIM, 11'd1,    4'd0,  1'b0, 22'h000000, 1'b0, 4'd0}
   };

   // ages the set until some way is at the top, then names the first such way
   function automatic logic [WAY_IDX_W-1:0] age_and_pick(input logic [SET_IDX_W-1:0] set_idx);
      int base;
      logic [1:0] peak;
      logic [1:0] lift;
      logic [WAY_IDX_W-1:0] pick;
      base = int'(set_idx) * NUM_WAYS;
      peak = 2'd0;
      for (int w = 0; w < NUM_WAYS; w++)
         if (line_rrpv[base + w] > peak) peak = line_rrpv[base + w];
      lift = RRPV_TOP - peak;
      for (int w = 0; w < NUM_WAYS; w++)
         line_rrpv[base + w] = line_rrpv[base + w] + lift;
      pick = '0;
      // walk downward so the lowest matching way wins
      for (int w = NUM_WAYS - 1; w >= 0; w--)
         if (line_rrpv[base + w] == RRPV_TOP) pick = WAY_IDX_W'(w);
      return pick;
   endfunction

   // hit promotes and rewards; fill punishes a hot victim and inserts by counter
   function automatic void apply_access(input logic [SET_IDX_W-1:0] set_idx,
                                        input logic [WAY_IDX_W-1:0] way,
                                        input logic hit,
                                        input logic [PC_W-1:0] pc);
      int line;
      logic [SIG_W-1:0] old_sig;
      logic [SIG_W-1:0] fresh_sig;
      line = int'(set_idx) * NUM_WAYS + int'(way);
      old_sig = line_sig[line];
      if (hit) begin
         line_rrpv[line] = 2'd0;
         if (sig_ctr[old_sig] < CTR_MAX) sig_ctr[old_sig] = sig_ctr[old_sig] + 3'd1;
      end else begin
         if (line_rrpv[line] == 2'd0 && sig_ctr[old_sig] > 3'd0)
            sig_ctr[old_sig] = sig_ctr[old_sig] - 3'd1;
         fresh_sig = SIG_W'((pc >> 2) ^ (pc >> (2 + SIG_W)));
         line_sig[line] = fresh_sig;
         line_rrpv[line] = (sig_ctr[fresh_sig] > insert_thr) ? 2'd0 : RRPV_TOP;
      end
   endfunction

   // drives one request, waits until it is accepted and updates the prediction
   task automatic issue_request(input logic act,
                                input logic [SET_IDX_W-1:0] set_idx,
                                input logic [WAY_IDX_W-1:0] way,
                                input logic hit,
                                input logic [PC_W-1:0] pc,
                                input logic typed = 1'b0,
                                input logic [WAY_IDX_W-1:0] typed_way = '0);
      int gap;
      logic [WAY_IDX_W-1:0] predicted;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_set_index <= set_idx;
      req_way_index <= way;
      req_was_hit   <= hit;
      req_pc_bits   <= pc;
      do @(posedge clock); while (!req_ready);
      if (act == ACT_VICTIM) begin
         predicted = age_and_pick(set_idx);
         last_victim = predicted;
         victim_ways_due.push_back(typed ? typed_way : predicted);
      end else begin
         apply_access(set_idx, way, hit, pc);
      end
   endtask

   // waits for every owed victim, then lets a trailing update finish
   task automatic drain;
      req_valid <= 1'b0;
      while (victim_ways_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write of the insertion threshold, then a read back of it
   task automatic write_threshold(input logic [THR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= THR_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      insert_thr = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[THR_W-1:0] !== value) begin
         $display("%0t threshold read back: expected %0d, got %0d", $realtime, value,
                  prdata[THR_W-1:0]);
         mismatch_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // random traffic: mostly victim-then-fill and hits on two hot sets, some noise
   task automatic run_random(input int item_goal);
      logic [SET_IDX_W-1:0] pool_set [2];
      logic [PC_W-1:0]      pool_pc  [6];
      logic [SET_IDX_W-1:0] set_idx;
      logic [PC_W-1:0]      pc;
      int issued;
      int roll;
      pool_set[0] = SET_IDX_W'($urandom_range(NUM_SETS - 1));
      pool_set[1] = ~pool_set[0];
      foreach (pool_pc[i]) pool_pc[i] = PC_W'($urandom);
      issued = 0;
      while (issued < item_goal) begin
         roll    = $urandom_range(99);
         set_idx = pool_set[$urandom_range(1)];
         pc      = pool_pc[$urandom_range(5)];
         if (roll < 35) begin
            // miss flow: ask for a victim, then fill the way it named
            issue_request(ACT_VICTIM, set_idx, '0, 1'b0, pc);
            issue_request(ACT_UPDATE, set_idx, last_victim, 1'b0, pc);
            issued += 2;
         end else if (roll < 70) begin
            issue_request(ACT_UPDATE, set_idx, WAY_IDX_W'($urandom_range(15)), 1'b1, pc);
            issued++;
         end else if (roll < 82) begin
            issue_request(ACT_UPDATE, set_idx, WAY_IDX_W'($urandom_range(15)), 1'b0, pc);
            issued++;
         end else begin
            issue_request(1'($urandom_range(1)), SET_IDX_W'($urandom_range(NUM_SETS - 1)),
                          WAY_IDX_W'($urandom_range(15)), 1'($urandom_range(1)),
                          PC_W'($urandom));
            issued++;
         end
      end
   endtask

   // result side: random back-pressure and in-order compare against the due list
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (victim_ways_due.size() == 0) begin
               $display("%0t unexpected victim transfer: expected none, got %0d", $realtime,
                        rsp_victim_way);
               mismatch_count++;
            end else if (rsp_victim_way !== victim_ways_due[0]) begin
               $display("%0t victim_way: expected %0d, got %0d", $realtime,
                        victim_ways_due[0], rsp_victim_way);
               mismatch_count++;
               void'(victim_ways_due.pop_front());
            end else begin
               void'(victim_ways_due.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      for (int i = 0; i < LINE_COUNT; i++) begin
         line_rrpv[i] = RRPV_TOP;
         line_sig[i]  = '0;
      end
      for (int i = 0; i < (1 << SIG_W); i++) sig_ctr[i] = CTR_MID;
      insert_thr = THR_RESET;
      last_victim = '0;
      send_idle_pct  = 18;
      recv_stall_pct = 63;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows at the reset threshold; the clearing pass holds off the first one
      for (int r = 0; r < DIR_ROWS; r++)
         issue_request(dir_table[r].action, dir_table[r].set_idx, dir_table[r].way,
                       dir_table[r].hit, dir_table[r].pc, dir_table[r].typed,
                       dir_table[r].typed_way);
      drain();

      // lowest threshold: nearly every fill goes in hot, so sets age often
      write_threshold(3'd0);
      run_random(130);
      drain();

      // highest threshold: no counter can exceed it, every fill goes in cold
      send_idle_pct  = 63;
      recv_stall_pct = 18;
      write_threshold(3'd7);
      run_random(130);
      drain();

      // a middle threshold with both sides streaming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_threshold(3'd5);
      run_random(130);
      drain();

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hang guard
   initial begin
      #400us;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/ship_pkg.sv
hdl/ship_set_map.sv
hdl/ship_line_store.sv
hdl/ship_sig_table.sv
hdl/ship_rrip_replacement.sv
tb/tb_top.sv
